/* rtl/core/assert_macros.svh */
// Assertion macros shared by the tone generator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define STS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
// Checked on every edge, reset included.
`define STS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define STS_ASSERT(lbl, clk, rstn, prop)
`define STS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* rtl/core/sts_pkg.sv */
// Shared widths, reset values and register codes for the square tone core.
// No dependencies.
package sts_pkg;
    localparam int FREQ_W   = 24;
    localparam int LEN_W    = 20;
    localparam int COEFF_W  = 16;
    localparam int PPH_W    = 24;
    localparam int AMP_W    = 15;
    localparam int SAMPLE_W = 16;
    localparam int S_DATA_W = 48;  // freq + length, padded to bytes
    localparam int CFG_AW   = 4;
    localparam int CFG_DW   = 32;

    // Shift-add multiplier geometry (24 x 24)
    localparam int MUL_W    = 24;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int INC_W    = PROD_W - 8;
    localparam int GLIDE_SH = 16;

    localparam int PHASE_BITS_DEF = 32;

    localparam logic [COEFF_W-1:0] GLIDE_RST = 16'd3277;
    localparam logic [PPH_W-1:0]   PPH_RST   = 24'd97392;
    localparam logic [AMP_W-1:0]   AMP_RST   = 15'd2000;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_GLIDE = 2'd0;
    localparam logic [1:0] REG_PPH   = 2'd1;
    localparam logic [1:0] REG_AMP   = 2'd2;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_START = 1'b1;
endpackage

/* rtl/core/square_tone_glide_synth_core.sv */
// Square tone generator with exponential glide; top level.
// Start-tone item: accepted, no result. Silent tick: result without a multiplier pass.
// Sounding tick: result after the two passes through the bit-serial multiplier; one item
// is in work at a time.
// aresetn (synchronous, active low) clears state and restores register defaults.
// Depends on sts_pkg, sts_mul and assert_macros.svh.
`include "assert_macros.svh"
module square_tone_glide_synth_core #(
    parameter int PHASE_BITS = sts_pkg::PHASE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sts_pkg::S_DATA_W-1:0]  s_tdata,  // [23:0] tone_freq, [43:24] tone_length
    input  logic                          s_tuser,  // [0] mode
    // Result items
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sts_pkg::SAMPLE_W-1:0]  m_tdata,  // [15:0] sample
    output logic                          m_tuser,  // [0] active
    // Configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sts_pkg::CFG_AW-1:0]    paddr,
    input  logic [sts_pkg::CFG_DW-1:0]    pwdata,
    output logic [sts_pkg::CFG_DW-1:0]    prdata,
    output logic                          pready
);
    localparam int FW = sts_pkg::FREQ_W;
    localparam int LW = sts_pkg::LEN_W;
    localparam int MW = sts_pkg::MUL_W;
    localparam int PW = sts_pkg::PROD_W;
    localparam int IW = sts_pkg::INC_W;
    localparam int SW = sts_pkg::SAMPLE_W;
    localparam int GP = sts_pkg::GLIDE_SH + FW; // glide product width

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_GLIDE  = 3'd1;
    localparam logic [2:0] ST_LAUNCH = 3'd2;
    localparam logic [2:0] ST_PHASE  = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    // Configuration registers
    logic [sts_pkg::COEFF_W-1:0] glide_reg;
    logic [sts_pkg::PPH_W-1:0]   pph_reg;
    logic [sts_pkg::AMP_W-1:0]   amp_reg;
    logic                        cfg_wr;

    // Generator state
    logic [2:0]            state_reg;
    logic [FW-1:0]         cur_freq_reg;
    logic [FW-1:0]         tgt_freq_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [LW-1:0]         left_reg;
    logic                  dneg_reg;

    // Result holding and output registers
    logic [SW-1:0] res_sample_reg;
    logic          res_active_reg;
    logic          m_tvalid_reg;
    logic [SW-1:0] m_tdata_reg;
    logic          m_tuser_reg;

    // Item fields
    logic          in_mode;
    logic [FW-1:0] in_freq;
    logic [LW-1:0] in_len;
    logic          s_acc;

    // Datapath
    logic [FW:0]           diff;
    logic [MW-1:0]         mag;
    logic                  mul_start;
    logic [MW-1:0]         mul_a;
    logic [MW-1:0]         mul_b;
    logic                  mul_done;
    logic [PW-1:0]         mul_prod;
    logic [GP-1:0]         gprod;
    logic [GP-1:0]         gceil;
    logic [FW-1:0]         nf;
    logic [IW-1:0]         inc;
    logic [PHASE_BITS-1:0] inc_ext;
    logic [PHASE_BITS-1:0] phase_next;
    logic [SW-1:0]         amp_pos;
    logic [SW-1:0]         amp_neg;
    logic                  out_free;
    logic                  res_amp_ok;

    assign in_mode = s_tuser;
    assign in_freq = s_tdata[FW-1:0];
    assign in_len  = s_tdata[FW+LW-1:FW];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    // APB register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glide_reg <= sts_pkg::GLIDE_RST;
            pph_reg   <= sts_pkg::PPH_RST;
            amp_reg   <= sts_pkg::AMP_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                sts_pkg::REG_GLIDE: glide_reg <= pwdata[sts_pkg::COEFF_W-1:0];
                sts_pkg::REG_PPH:   pph_reg   <= pwdata[sts_pkg::PPH_W-1:0];
                sts_pkg::REG_AMP:   amp_reg   <= pwdata[sts_pkg::AMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            sts_pkg::REG_GLIDE: prdata = sts_pkg::CFG_DW'(glide_reg);
            sts_pkg::REG_PPH:   prdata = sts_pkg::CFG_DW'(pph_reg);
            sts_pkg::REG_AMP:   prdata = sts_pkg::CFG_DW'(amp_reg);
            default:            prdata = '0;
        endcase
    end

    // Signed distance to target, split into sign and magnitude
    assign diff = {1'b0, tgt_freq_reg} - {1'b0, cur_freq_reg};
    assign mag  = diff[FW] ? MW'(-diff) : diff[MW-1:0];

    // Shared multiplier: glide pass from idle, phase-step pass from launch
    assign mul_start = (s_acc && in_mode == sts_pkg::MODE_TICK && left_reg != '0)
                       || (state_reg == ST_LAUNCH);
    assign mul_a = (state_reg == ST_LAUNCH) ? cur_freq_reg : mag;
    assign mul_b = (state_reg == ST_LAUNCH) ? pph_reg : MW'(glide_reg);

    sts_mul #(
        .WA (MW),
        .WB (MW)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    // Glide: floor for a rising step, ceiling of magnitude for a falling one
    assign gprod = mul_prod[GP-1:0];
    assign gceil = gprod + GP'(16'hFFFF);
    assign nf = dneg_reg ? (cur_freq_reg - gceil[GP-1:sts_pkg::GLIDE_SH])
                         : (cur_freq_reg + gprod[GP-1:sts_pkg::GLIDE_SH]);

    // Phase increment, fitted to the accumulator width
    assign inc = mul_prod[PW-1:PW-IW];
    generate
        if (PHASE_BITS > IW) begin : g_inc_pad
            assign inc_ext = {{(PHASE_BITS - IW){1'b0}}, inc};
        end else begin : g_inc_cut
            assign inc_ext = inc[PHASE_BITS-1:0];
        end
    endgenerate
    assign phase_next = phase_reg + inc_ext;

    assign amp_pos  = {1'b0, amp_reg};
    assign amp_neg  = -amp_pos;
    assign out_free = !m_tvalid_reg || m_tready;
    assign res_amp_ok = (m_tdata == amp_pos) || (m_tdata == amp_neg);

    // Sequencer and generator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cur_freq_reg <= '0;
            tgt_freq_reg <= '0;
            phase_reg    <= '0;
            left_reg     <= '0;
            dneg_reg     <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        if (in_mode == sts_pkg::MODE_START) begin
                            tgt_freq_reg <= in_freq;
                            if (left_reg == '0) begin
                                cur_freq_reg <= in_freq;
                            end
                            left_reg <= in_len;
                        end else if (left_reg == '0) begin
                            state_reg <= ST_DONE;
                        end else begin
                            dneg_reg  <= diff[FW];
                            left_reg  <= left_reg - 1'b1;
                            state_reg <= ST_GLIDE;
                        end
                    end
                end
                ST_GLIDE: begin
                    if (mul_done) begin
                        cur_freq_reg <= nf;
                        state_reg    <= ST_LAUNCH;
                    end
                end
                ST_LAUNCH: begin
                    state_reg <= ST_PHASE;
                end
                ST_PHASE: begin
                    if (mul_done) begin
                        phase_reg <= phase_next;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_acc) begin
            res_sample_reg <= '0;
            res_active_reg <= 1'b0;
        end else if (state_reg == ST_PHASE && mul_done) begin
            res_sample_reg <= phase_next[PHASE_BITS-1] ? amp_neg : amp_pos;
            res_active_reg <= 1'b1;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_tdata_reg <= res_sample_reg;
            m_tuser_reg <= res_active_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Checks
    `STS_ASSERT(a_silent_zero, aclk, aresetn, (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    `STS_ASSERT(a_active_amp, aclk, aresetn, (m_tvalid && m_tuser) |-> res_amp_ok)
    `STS_ASSERT(a_phase_to_done, aclk, aresetn, (state_reg == ST_PHASE && mul_done) |=> (state_reg == ST_DONE))
endmodule

/* rtl/core/sts_mul.sv */
// Radix-2 shift-add multiplier, one multiplier bit per cycle.
// Depends on nothing; used by the square tone core.
module sts_mul #(
    parameter int WA = 24,
    parameter int WB = 24
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WA-1:0]    a,
    input  logic [WB-1:0]    b,
    output logic             done,
    output logic [WA+WB-1:0] product
);
    localparam int CW = (WB > 1) ? $clog2(WB) : 1;

    logic [WA+WB-1:0] acc_reg;
    logic [WA-1:0]    a_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [WA:0]      sum;

    // Partial sum: upper half plus the multiplicand when the scanned bit is set
    assign sum = {1'b0, acc_reg[WA+WB-1:WB]} + (acc_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(WB - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: accumulator shifts right as multiplier bits are consumed
    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= {{WA{1'b0}}, b};
            a_reg   <= a;
        end else if (busy_reg) begin
            acc_reg <= {sum, acc_reg[WB-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule
